// ----- design/ilir_pkg.sv -----
// Shared types and constants for the indexed list block.
// No dependencies; used by ilir_cell, indexed_list_insert_remove and ilir_checker.
package ilir_pkg;

  // Width of one stored move record: from_row, from_col, to_row, to_col, tag.
  localparam int unsigned RecW = 19;

  // Width of the capacity limit register and its reset value.
  localparam int unsigned CapW = 7;
  localparam logic [CapW-1:0] CAP_RESET = 7'd64;

  // Register index of capacity_limit on the configuration port.
  localparam logic [0:0] REG_CAP_IDX = 1'b0;

  typedef logic [RecW-1:0] rec_t;

  // Operation codes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_INSERT_AT   = 3'd0,
    OP_INSERT_LAST = 3'd1,
    OP_REMOVE_AT   = 3'd2,
    OP_REMOVE_LAST = 3'd3,
    OP_READ_AT     = 3'd4,
    OP_READ_LAST   = 3'd5,
    OP_CLEAR       = 3'd6
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ----- design/ilir_cell.sv -----
// One slot of the list: holds a record and shifts with its neighbors.
// Depends on ilir_pkg.
module ilir_cell #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  ilir_pkg::cell_ctl_t ctl_i,
  input  logic [IdxW-1:0]     idx_i,
  input  ilir_pkg::rec_t      rec_i,
  input  ilir_pkg::rec_t      below_i,
  input  ilir_pkg::rec_t      above_i,
  output ilir_pkg::rec_t      entry_o,
  output ilir_pkg::rec_t      tap_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  ilir_pkg::rec_t entry_q, entry_d;

  // Insert moves entries at and above the index up one slot; remove pulls down those above.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (MyIdx > idx_i) begin
        entry_d = below_i;
      end else if (MyIdx == idx_i) begin
        entry_d = rec_i;
      end
    end else if (ctl_i.rem) begin
      if (MyIdx >= idx_i) begin
        entry_d = above_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // The addressed cell puts its record on the read tap, all others drive zero.
  assign tap_o   = (MyIdx == idx_i) ? entry_q : '0;
  assign entry_o = entry_q;

endmodule

// ----- design/indexed_list_insert_remove.sv -----
// Top level of the indexed list: chain of record cells, count and pipeline.
// Depends on ilir_pkg and ilir_cell.
//
// An ordered list of move records with insert, remove, read and clear by index.
// Input words arrive on the s_axis channel: the operation code in tuser, the
// position and the record to insert in tdata. Each input word yields exactly
// one result word on the m_axis channel with status, the record read, the live
// count and the full and empty flags.
// The capacity limit is set through the APB port at byte address 0.
// Each accepted word goes through the gather stage and the result register.
// One word is accepted every cycle unless the receiver stalls: all cells
// shift together at the acceptance edge, and a read gathers the addressed
// cell through a two-level registered OR tree. When the receiver stalls, the
// result register and the gather stage hold their words and s_axis_tready
// drops once both are occupied. Reset empties the list, sets the capacity
// limit to 64 and clears all valid flags. The record cells are not reset; no
// entry is read before it is written.
module indexed_list_insert_remove #(
  parameter int unsigned MaxDepth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: position[6:0], entry_from_row[9:7], entry_from_col[12:10],
  // entry_to_row[15:13], entry_to_col[18:16], entry_tag[25:19], zero pad.
  input  logic [31:0] s_axis_tdata,
  // tuser: op[2:0].
  input  logic [2:0]  s_axis_tuser,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], out_from_row[5:2], out_from_col[9:6], out_to_row[13:10],
  // out_to_col[17:14], out_tag[25:18], live_count[32:26], is_full[33],
  // is_empty[34], zero pad.
  output logic [39:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned CntW = $clog2(MaxDepth + 1);
  localparam int unsigned CmpW = (CntW > 7) ? CntW : 7;
  localparam int unsigned NGrp = (MaxDepth + 7) / 8;
  localparam int unsigned NPad = NGrp * 8;

  // ---------------------------------------------------------------------------
  // Configuration register.
  logic [ilir_pkg::CapW-1:0] cap_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ilir_pkg::REG_CAP_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ilir_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[ilir_pkg::CapW-1:0];
    end
  end

  assign prdata = (paddr[2] == ilir_pkg::REG_CAP_IDX) ?
                  {{(32 - ilir_pkg::CapW){1'b0}}, cap_q} : 32'd0;

  // ---------------------------------------------------------------------------
  // Input unpacking.
  ilir_pkg::op_e  op;
  logic [6:0]     position;
  ilir_pkg::rec_t rec;

  assign op       = ilir_pkg::op_e'(s_axis_tuser);
  assign position = s_axis_tdata[6:0];
  assign rec      = {s_axis_tdata[9:7], s_axis_tdata[12:10], s_axis_tdata[15:13],
                     s_axis_tdata[18:16], s_axis_tdata[25:19]};

  // ---------------------------------------------------------------------------
  // Pipeline handshakes.
  logic s1_valid_q, out_valid_q;
  logic s1_adv, s_acc;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Decode, bound checks and next count.
  logic [CntW-1:0]      cnt_q;
  logic [CmpW-1:0]      cnt_ext, cap_ext, lim, idx, cnt_new;
  logic                 is_ins, is_rem, is_rd, is_clr, bad_op;
  ilir_pkg::status_e    status;
  ilir_pkg::cell_ctl_t  ctl;

  assign cnt_ext = CmpW'(cnt_q);
  assign cap_ext = CmpW'(cap_q);

  // Effective limit: zero acts as one, and the depth caps it.
  always_comb begin
    if (cap_ext == '0) begin
      lim = CmpW'(1);
    end else if (cap_ext > CmpW'(MaxDepth)) begin
      lim = CmpW'(MaxDepth);
    end else begin
      lim = cap_ext;
    end
  end

  // Operation decoder; the last variants index by the count.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    is_rd  = 1'b0;
    is_clr = 1'b0;
    bad_op = 1'b0;
    idx    = CmpW'(position);
    unique case (op)
      ilir_pkg::OP_INSERT_AT: begin
        is_ins = 1'b1;
      end
      ilir_pkg::OP_INSERT_LAST: begin
        is_ins = 1'b1;
        idx    = cnt_ext;
      end
      ilir_pkg::OP_REMOVE_AT: begin
        is_rem = 1'b1;
      end
      ilir_pkg::OP_REMOVE_LAST: begin
        is_rem = 1'b1;
        idx    = cnt_ext - CmpW'(1);
      end
      ilir_pkg::OP_READ_AT: begin
        is_rd = 1'b1;
      end
      ilir_pkg::OP_READ_LAST: begin
        is_rd = 1'b1;
        idx   = cnt_ext - CmpW'(1);
      end
      ilir_pkg::OP_CLEAR: begin
        is_clr = 1'b1;
      end
      default: begin
        bad_op = 1'b1;
      end
    endcase
  end

  // Status and count after the operation. On an empty list the last variants
  // wrap the index to all ones, which fails the bound check.
  always_comb begin
    status  = ilir_pkg::ST_OK;
    cnt_new = cnt_ext;
    if (is_ins) begin
      if (idx > cnt_ext) begin
        status = ilir_pkg::ST_BAD_INDEX;
      end else if (cnt_ext >= lim) begin
        status = ilir_pkg::ST_FULL;
      end else begin
        cnt_new = cnt_ext + CmpW'(1);
      end
    end
    if (is_rem) begin
      if (idx >= cnt_ext) begin
        status = ilir_pkg::ST_BAD_INDEX;
      end else begin
        cnt_new = cnt_ext - CmpW'(1);
      end
    end
    if (is_rd && (idx >= cnt_ext)) begin
      status = ilir_pkg::ST_BAD_INDEX;
    end
    if (is_clr) begin
      cnt_new = '0;
    end
    if (bad_op) begin
      status = ilir_pkg::ST_BAD_INDEX;
    end
  end

  assign ctl.ins = s_acc && is_ins && (status == ilir_pkg::ST_OK);
  assign ctl.rem = s_acc && is_rem && (status == ilir_pkg::ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s_acc) begin
      cnt_q <= CntW'(cnt_new);
    end
  end

  // ---------------------------------------------------------------------------
  // Chain of record cells.
  ilir_pkg::rec_t entry [MaxDepth];
  ilir_pkg::rec_t tap   [NPad];

  for (genvar i = 0; i < NPad; i++) begin : g_cell
    if (i < MaxDepth) begin : g_live
      ilir_pkg::rec_t below, above;
      if (i == 0) begin : g_first
        assign below = rec;
      end else begin : g_mid_lo
        assign below = entry[i-1];
      end
      if (i == MaxDepth - 1) begin : g_last
        assign above = entry[i];
      end else begin : g_mid_hi
        assign above = entry[i+1];
      end
      ilir_cell #(
        .IdxW    (IdxW),
        .CellIdx (i)
      ) u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .idx_i   (idx[IdxW-1:0]),
        .rec_i   (rec),
        .below_i (below),
        .above_i (above),
        .entry_o (entry[i]),
        .tap_o   (tap[i])
      );
    end else begin : g_pad
      assign tap[i] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Gather stage: first OR level over groups of eight taps.
  ilir_pkg::rec_t grp_d [NGrp];
  ilir_pkg::rec_t grp_q [NGrp];

  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < 8; k++) begin
        grp_d[g] = grp_d[g] | tap[g*8 + k];
      end
    end
  end

  logic              s1_rd_ok_q, s1_rd_bad_q, s1_full_q, s1_empty_q;
  ilir_pkg::status_e s1_status_q;
  logic [6:0]        s1_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      grp_q       <= grp_d;
      s1_status_q <= status;
      s1_rd_ok_q  <= is_rd && (status == ilir_pkg::ST_OK);
      s1_rd_bad_q <= is_rd && (status != ilir_pkg::ST_OK);
      s1_cnt_q    <= cnt_new[6:0];
      s1_full_q   <= (cnt_new >= lim);
      s1_empty_q  <= (cnt_new == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: second OR level and result formatting.
  ilir_pkg::rec_t rd_rec;
  logic [3:0]     f_from_row, f_from_col, f_to_row, f_to_col;
  logic [7:0]     f_tag;

  always_comb begin
    rd_rec = '0;
    for (int g = 0; g < NGrp; g++) begin
      rd_rec = rd_rec | grp_q[g];
    end
  end

  always_comb begin
    if (s1_rd_ok_q) begin
      f_from_row = {1'b0, rd_rec[18:16]};
      f_from_col = {1'b0, rd_rec[15:13]};
      f_to_row   = {1'b0, rd_rec[12:10]};
      f_to_col   = {1'b0, rd_rec[9:7]};
      f_tag      = {1'b0, rd_rec[6:0]};
    end else if (s1_rd_bad_q) begin
      f_from_row = '1;
      f_from_col = '1;
      f_to_row   = '1;
      f_to_col   = '1;
      f_tag      = '1;
    end else begin
      f_from_row = '0;
      f_from_col = '0;
      f_to_row   = '0;
      f_to_col   = '0;
      f_tag      = '0;
    end
  end

  logic [39:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q <= {5'd0, s1_empty_q, s1_full_q, s1_cnt_q, f_tag, f_to_col, f_to_row,
                     f_from_col, f_from_row, s1_status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- design/ilir_checker.sv -----
// Port-level checks on the result channel of the indexed list.
// Depends on ilir_pkg; bound to indexed_list_insert_remove below.
module ilir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The status code is never the unused value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == ilir_pkg::ST_OK) ||
                      (m_axis_tdata[1:0] == ilir_pkg::ST_BAD_INDEX) ||
                      (m_axis_tdata[1:0] == ilir_pkg::ST_FULL))
    else $error("unused status code");

  // The empty flag matches a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34] == (m_axis_tdata[32:26] == 7'd0)))
    else $error("empty flag disagrees with count");

  // A full report comes only with a non-empty list flagged full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == ilir_pkg::ST_FULL) |->
      m_axis_tdata[33] && !m_axis_tdata[34])
    else $error("full status without full flag");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
